### hdl/text_console_writer_with_scroll_assert.svh
// Assertion macros for the text console writer.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_WITH_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_WITH_SCROLL_ASSERT_SVH
`ifndef SYNTH
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/tcw_pkg.sv
// Shared types, command codes and operation kinds for the text console writer.
// No dependencies.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CHAR_W   = 8;
    localparam int CURSOR_W = 11;
    localparam int KIND_W   = 3;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

    localparam logic [KIND_W-1:0] K_NOP   = 3'd0;
    localparam logic [KIND_W-1:0] K_PUT   = 3'd1;
    localparam logic [KIND_W-1:0] K_NL    = 3'd2;
    localparam logic [KIND_W-1:0] K_CLEAR = 3'd3;
    localparam logic [KIND_W-1:0] K_READ  = 3'd4;

    typedef struct packed {
        logic [1:0]        command;
        logic [CHAR_W-1:0] char_code;
        logic [4:0]        read_row;
        logic [6:0]        read_col;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0]   cell_char;
        logic [CURSOR_W-1:0] cursor_position;
        logic                did_scroll;
    } t_out_item;

    // classified operation handed from the front to the back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
        logic [4:0]        read_row;
        logic [6:0]        read_col;
    } t_op;

endpackage

### hdl/text_console_writer_with_scroll.sv
// Text console writer: top level joining front end, operation queue and back end.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
//
// Usage: each input beat carries one command (put character, clear, read cell).
// Every accepted beat yields exactly one output beat with the read character,
// the cursor cell index after the command and a scroll flag, in order.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A command passes the front register, the queue and the back end in turn.
// A put into a row not yet written since reset, clear or scroll first blanks
// that row, one RAM write per column.
// The back end works on one command at a time (pop, execute, result), adds a
// RAM wait for a read of a written row, another execute for a scroll and the
// row blank, all bound by the single write port of the screen RAM.
// Scrolling rotates a row base pointer, so no cells are moved.
// Reset marks every row blank through per-row valid bits; no clearing pass
// runs and the block takes input right away.
// When the receiver stalls, the result register holds its beat; the back end,
// the queue and the front register take up to four more commands before
// o_stall rises.
module text_console_writer_with_scroll import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic f_valid;
    logic f_stall;
    t_op  f_op;
    logic q_valid;
    logic q_pop;
    t_op  q_op;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (i_item),
        .o_push_valid (f_valid),
        .i_push_stall (f_stall),
        .o_op         (f_op)
    );

    tcw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_stall (f_stall),
        .i_op         (f_op),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_op         (q_op)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_op    (q_op),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

### hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tcw_front.sv
// Front end: accepts input beats, classifies them into operations and holds
// one operation for the queue. Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_push_valid,
    input  logic     i_push_stall,
    output t_op      o_op
);

    logic r_valid;
    logic n_valid;
    t_op  r_op;
    t_op  n_op;
    logic accept;

    assign o_stall = r_valid && i_push_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_op.char_code = i_item.char_code;
        n_op.read_row  = i_item.read_row;
        n_op.read_col  = i_item.read_col;
        case (i_item.command)
            CMD_PUT: begin
                if (i_item.char_code == CH_NUL) begin
                    n_op.kind = K_NOP;
                end else if (i_item.char_code == CH_NEWLINE) begin
                    n_op.kind = K_NL;
                end else begin
                    n_op.kind = K_PUT;
                end
            end
            CMD_CLEAR: n_op.kind = K_CLEAR;
            CMD_READ: begin
                // drop reads outside the screen
                if ((32'(i_item.read_row) < 32'(ROWS)) && (32'(i_item.read_col) < 32'(COLUMNS))) begin
                    n_op.kind = K_READ;
                end else begin
                    n_op.kind = K_NOP;
                end
            end
            default: n_op.kind = K_NOP;
        endcase
    end

    assign n_valid = accept || (r_valid && i_push_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

    assign o_push_valid = r_valid;
    assign o_op         = r_op;

endmodule

### hdl/tcw_queue.sv
// Two-entry operation queue between the front and back ends.
// Depends on tcw_pkg.
module tcw_queue import tcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_stall,
    input  t_op  i_op,
    output logic o_valid,
    input  logic i_pop,
    output t_op  o_op
);

    t_op        r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_stall = (r_count == 2'd2);
    assign push         = i_push_valid && !o_push_stall;
    assign o_valid      = (r_count != 2'd0);
    assign pop          = i_pop && o_valid;
    assign o_op         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

### hdl/tcw_back.sv
// Back end: executes queued operations against the screen RAM, the row
// valid bits, the scroll base and the cursor. Depends on tcw_pkg and tcw_ram.
`include "text_console_writer_with_scroll_assert.svh"
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_pop,
    input  t_op       i_q_op,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PR_W   = $clog2(ROWS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int SUM_W  = ROW_W + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_FILL   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        r_state,   n_state;
    logic [ROWS-1:0]   r_row_vld, n_row_vld;
    logic [PR_W-1:0]   r_base,    n_base;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic              r_out_valid, n_out_valid;
    t_op               r_op,      n_op;
    logic              r_scr,     n_scr;
    logic [CHAR_W-1:0] r_cell,    n_cell;
    logic [COL_W-1:0]  r_fill_col, n_fill_col;
    t_out_item         r_out_item, n_out_item;

    logic [SUM_W-1:0]  put_sum,  rd_sum;
    logic [PR_W-1:0]   put_prow, rd_prow;
    logic [PR_W-1:0]   base_inc;
    logic [ADDR_W-1:0] put_addr, fill_addr, rd_addr;
    logic              exec_scroll;
    logic              out_free;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [CHAR_W-1:0] ram_rdata;

    // map logical rows onto the circular row store
    always_comb begin
        put_sum = SUM_W'(r_base) + SUM_W'(r_cur_row);
        if (put_sum >= SUM_W'(ROWS)) begin
            put_sum = put_sum - SUM_W'(ROWS);
        end
        rd_sum = SUM_W'(r_base) + SUM_W'(r_op.read_row);
        if (rd_sum >= SUM_W'(ROWS)) begin
            rd_sum = rd_sum - SUM_W'(ROWS);
        end
    end

    assign put_prow  = PR_W'(put_sum);
    assign rd_prow   = PR_W'(rd_sum);
    assign base_inc  = (r_base == PR_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
    assign put_addr  = ADDR_W'(put_prow * COLUMNS) + ADDR_W'(r_cur_col);
    assign fill_addr = ADDR_W'(put_prow * COLUMNS) + ADDR_W'(r_fill_col);
    assign rd_addr   = ADDR_W'(rd_prow * COLUMNS) + ADDR_W'(COL_W'(r_op.read_col));

    assign exec_scroll = ((r_op.kind == K_PUT) || (r_op.kind == K_NL)) &&
                         (r_cur_row == ROW_W'(ROWS));
    assign out_free    = !(r_out_valid && i_stall);

    always_comb begin
        n_state     = r_state;
        n_row_vld   = r_row_vld;
        n_base      = r_base;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_out_valid = r_out_valid && i_stall;
        n_op        = r_op;
        n_scr       = r_scr;
        n_cell      = r_cell;
        n_fill_col  = r_fill_col;
        n_out_item  = r_out_item;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = put_addr;
        ram_wdata   = r_op.char_code;
        ram_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_op;
                    n_scr   = 1'b0;
                    n_cell  = CH_NUL;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op.kind)
                    K_PUT, K_NL: begin
                        if (exec_scroll) begin
                            // old top row becomes the blank bottom row
                            n_row_vld[r_base] = 1'b0;
                            n_base            = base_inc;
                            n_cur_row         = ROW_W'(ROWS - 1);
                            n_scr             = 1'b1;
                        end else if (r_op.kind == K_NL) begin
                            n_cur_row = r_cur_row + 1'b1;
                            n_cur_col = '0;
                            n_state   = S_DONE;
                        end else if (r_row_vld[put_prow]) begin
                            ram_we = 1'b1;
                            if (r_cur_col == COL_W'(COLUMNS - 1)) begin
                                n_cur_col = '0;
                                n_cur_row = r_cur_row + 1'b1;
                            end else begin
                                n_cur_col = r_cur_col + 1'b1;
                            end
                            n_state = S_DONE;
                        end else begin
                            n_fill_col = '0;
                            n_state    = S_FILL;
                        end
                    end
                    K_CLEAR: begin
                        n_row_vld = '0;
                        n_cur_row = '0;
                        n_cur_col = '0;
                        n_state   = S_DONE;
                    end
                    K_READ: begin
                        if (r_row_vld[rd_prow]) begin
                            ram_re  = 1'b1;
                            n_state = S_RDWAIT;
                        end else begin
                            n_cell  = CH_BLANK;
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FILL: begin
                // blank the row, dropping the new character in on the way
                ram_we    = 1'b1;
                ram_waddr = fill_addr;
                ram_wdata = (r_fill_col == r_cur_col) ? r_op.char_code : CH_BLANK;
                if (r_fill_col == COL_W'(COLUMNS - 1)) begin
                    n_row_vld[put_prow] = 1'b1;
                    if (r_cur_col == COL_W'(COLUMNS - 1)) begin
                        n_cur_col = '0;
                        n_cur_row = r_cur_row + 1'b1;
                    end else begin
                        n_cur_col = r_cur_col + 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_fill_col = r_fill_col + 1'b1;
                end
            end
            S_RDWAIT: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_item.cell_char       = (r_op.kind == K_READ) ? r_cell : CH_NUL;
                    n_out_item.cursor_position =
                        CURSOR_W'(r_cur_row * COLUMNS + r_cur_col);
                    n_out_item.did_scroll      = r_scr;
                    n_state                    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_vld   <= '0;
            r_base      <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_vld   <= n_row_vld;
            r_base      <= n_base;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_scr      <= n_scr;
        r_cell     <= n_cell;
        r_fill_col <= n_fill_col;
        r_out_item <= n_out_item;
    end

    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    `TCW_ASSERT_IMPL(a_past_end_col0, i_clk, i_rst_n, r_cur_row == ROW_W'(ROWS), r_cur_col == '0)
    `TCW_ASSERT_NEXT(a_scroll_bottom, i_clk, i_rst_n, (r_state == S_EXEC) && exec_scroll, (r_cur_row == ROW_W'(ROWS - 1)) && (r_state == S_EXEC))
    `TCW_ASSERT_NEXT(a_fill_exit, i_clk, i_rst_n, r_state == S_FILL, (r_state == S_FILL) || (r_state == S_DONE))
    `TCW_ASSERT_IMPL(a_scroll_put_only, i_clk, i_rst_n, (r_state == S_DONE) && r_scr, (r_op.kind == K_PUT) || (r_op.kind == K_NL))

endmodule
